FILE: hw/rtl/gss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the exp-table step for the spot splat accumulator.
// No dependencies; gss_mul, gss_div and the core import this package.
package gss_pkg;

   localparam int MAX_WIDTH       = 256;
   localparam int MAX_HEIGHT      = 256;
   localparam int PIX_DEPTH       = MAX_WIDTH * MAX_HEIGHT;
   localparam int PIX_AW          = $clog2(PIX_DEPTH);
   localparam int PIX_W           = 48;

   // exp(-16k/depth) table, 30 fraction bits; depth is a power of two
   localparam int EXP_TABLE_DEPTH = 1024;
   localparam int EXP_AW          = $clog2(EXP_TABLE_DEPTH);
   localparam int TAB_W           = 31;
   localparam int IDX_W           = EXP_AW + 37;

   localparam int MUL_A_W         = 64;
   localparam int MUL_B_W         = 32;
   localparam int MUL_P_W         = MUL_A_W + MUL_B_W;

   localparam int DIV_Q_W         = 57;
   localparam int DIV_D_W         = 32;

   localparam int SCALE_BASE      = 766;          // 2.9922 in 8 fraction bits
   localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
   localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
   localparam logic [22:0] RATIO_CAP = 23'd1 << 22;
   localparam logic [48:0] ADD_CAP   = 49'd1 << 48;
   localparam logic [TAB_W-1:0] TAB_ONE = 31'd1 << 30;

   localparam logic [63:0] EXP_D = (64'd1 << 34) / EXP_TABLE_DEPTH;

   // exp(-d) by Taylor sum to degree 10, 30 fraction bits
   function automatic logic [TAB_W-1:0] exp_step_fn();
      logic [63:0] term;
      logic [63:0] acc;
      term = 64'd1 << 30;
      acc  = term;
      term = (term * EXP_D) >> 30;        acc = acc - term;
      term = ((term * EXP_D) >> 30) / 2;  acc = acc + term;
      term = ((term * EXP_D) >> 30) / 3;  acc = acc - term;
      term = ((term * EXP_D) >> 30) / 4;  acc = acc + term;
      term = ((term * EXP_D) >> 30) / 5;  acc = acc - term;
      term = ((term * EXP_D) >> 30) / 6;  acc = acc + term;
      term = ((term * EXP_D) >> 30) / 7;  acc = acc - term;
      term = ((term * EXP_D) >> 30) / 8;  acc = acc + term;
      term = ((term * EXP_D) >> 30) / 9;  acc = acc - term;
      term = ((term * EXP_D) >> 30) / 10; acc = acc + term;
      return acc[TAB_W-1:0];
   endfunction

   localparam logic [TAB_W-1:0] EXP_STEP = exp_step_fn();

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_DRAW = 2'd1,
      KIND_READ = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_ADD_SIGMA    = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_RD_OUT,
      ST_DR_HW,
      ST_DR_WIN,
      ST_DR_DIV,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_ROW,
      ST_IDX,
      ST_FETCH,
      ST_ACC
   } state_type;

   typedef enum logic [3:0] {
      MOP_AX,
      MOP_AY,
      MOP_NORM,
      MOP_PEAK,
      MOP_RY,
      MOP_RY2,
      MOP_RX,
      MOP_RX2,
      MOP_ADD
   } mop_type;

endpackage

FILE: hw/rtl/gss_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the spot splat accumulator: request and response words.
// No dependencies.
interface gss_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [7:0]         pixel_col;
   logic [7:0]         pixel_row;
   logic signed [47:0] load_value;
   logic signed [23:0] spot_x;
   logic signed [23:0] spot_y;
   logic [15:0]        sigma_x;
   logic [15:0]        sigma_y;
   logic [23:0]        intensity;

   modport source (output valid, kind, pixel_col, pixel_row, load_value, spot_x, spot_y,
                   sigma_x, sigma_y, intensity, input ready);
   modport sink   (input valid, kind, pixel_col, pixel_row, load_value, spot_x, spot_y,
                   sigma_x, sigma_y, intensity, output ready);
endinterface

interface gss_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] read_value;
   logic               saturated_seen;

   modport source (output valid, read_value, saturated_seen, input ready);
   modport sink   (input valid, read_value, saturated_seen, output ready);
endinterface

FILE: hw/rtl/gss_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/gss_mul.sv
`timescale 1ns / 1ps
// 64x32 multiplier built from two 32x32 partial products, formed in turn and then summed.
// Depends on gss_pkg for operand widths.
module gss_mul import gss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic               done,
   output logic [MUL_P_W-1:0] prod
);

   logic [1:0]         step_ff, step_in;
   logic               done_ff, done_in;
   logic [31:0]        a_hi_ff, a_hi_in;
   logic [31:0]        b_ff, b_in;
   logic [63:0]        lo_ff, lo_in;
   logic [63:0]        hi_ff, hi_in;
   logic [MUL_P_W-1:0] prod_ff, prod_in;

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      a_hi_in = a_hi_ff;
      b_in    = b_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      prod_in = prod_ff;
      case (step_ff)
         2'd0: begin
            if (start) begin
               lo_in   = 64'(a[31:0]) * 64'(b);
               a_hi_in = a[63:32];
               b_in    = b;
               step_in = 2'd1;
            end
         end
         2'd1: begin
            hi_in   = 64'(a_hi_ff) * 64'(b_ff);
            step_in = 2'd2;
         end
         2'd2: begin
            prod_in = {hi_ff, 32'd0} + MUL_P_W'(lo_ff);
            done_in = 1'b1;
            step_in = 2'd0;
         end
         default: step_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_hi_ff <= a_hi_in;
      b_ff    <= b_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

FILE: hw/rtl/gss_div.sv
`timescale 1ns / 1ps
// Restoring divider for 2^(DIV_Q_W-1) / divisor, one quotient bit per cycle.
// Depends on gss_pkg for widths.
module gss_div import gss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_Q_W-1:0] quot
);

   localparam int CW = $clog2(DIV_Q_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [DIV_D_W-1:0] div_ff, div_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_Q_W-1:0] quot_ff, quot_in;

   always_comb begin
      logic [DIV_D_W:0] shifted;
      logic             ge;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      // numerator is a single one at its top bit
      shifted = {rem_ff, (cnt_ff == CW'(DIV_Q_W - 1))};
      ge      = shifted >= {1'b0, div_ff};
      if (busy_ff) begin
         rem_in  = ge ? DIV_D_W'(shifted - {1'b0, div_ff}) : shifted[DIV_D_W-1:0];
         quot_in = {quot_ff[DIV_Q_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIV_Q_W - 1);
         div_in  = divisor;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: hw/rtl/gaussian_spot_splat_accumulator_core.sv
`timescale 1ns / 1ps
// Spot splat accumulator top level: a 256x256 image of 48-bit pixels in block RAM.
// Depends on gss_pkg, gss_if, gss_ram, gss_mul and gss_div.
//
// Request words (req_ch) load a pixel, read a pixel or draw one elliptical
// Gaussian spot; only a read gives a response word (rsp_ch) with the pixel and
// the sticky saturation flag. Registers are written through csr_we/csr_index/
// csr_wdata; the user must write them only while the block is idle (the block
// itself does not enforce this), and they take effect for the next request.
// After reset the exp table RAM is filled with req_ch.ready low.
// Requests are handled one at a time:
//   load: the pixel is written as the request is taken.
//   read: the pixel goes to the response register, where one pending response
//         may wait while the next request is taken; a second read waits for it.
//   draw: setup runs the reciprocal divider and four multiplies; then each
//         window row takes two multiplies and each window pixel two more,
//         plus a third and a serial read-modify-write of the pixel RAM where
//         the table covers it, all on the shared multiplier.
// A stalled receiver only holds reads; loads and draws go on.
module gaussian_spot_splat_accumulator_core import gss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   gss_req_if.sink      req_ch,
   gss_rsp_if.source    rsp_ch,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [11:0]  csr_wdata
);

   state_type state_ff, state_in;
   mop_type   mop_ff, mop_in;

   logic [8:0]  width_ff, width_in;
   logic [8:0]  height_ff, height_in;
   logic [11:0] add_sigma_ff, add_sigma_in;
   logic        sat_ff, sat_in;

   logic [EXP_AW-1:0] init_k_ff, init_k_in;
   logic [TAB_W-1:0]  tab_val_ff, tab_val_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_sat_ff, rsp_sat_in;
   logic                    rd_inside_ff, rd_inside_in;

   logic signed [23:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [15:0]        sx_ff, sx_in, sy_ff, sy_in;
   logic [23:0]        inten_ff, inten_in;
   logic [20:0]        hwx_ff, hwx_in, hwy_ff, hwy_in;
   logic [31:0]        sxsy_ff, sxsy_in;
   logic signed [17:0] minx_ff, minx_in, maxx_ff, maxx_in;
   logic signed [17:0] miny_ff, miny_in, maxy_ff, maxy_in;
   logic signed [17:0] curx_ff, curx_in, cury_ff, cury_in;
   logic [DIV_Q_W-1:0] r_ff, r_in, ax_ff, ax_in, ay_ff, ay_in;
   logic [53:0]        norm_ff, norm_in;
   logic [50:0]        peak_ff, peak_in;
   logic [22:0]        rx_ff, rx_in, ry_ff, ry_in;
   logic [44:0]        rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [48:0]        add_ff, add_in;
   logic [PIX_AW-1:0]  row_base_ff, row_base_in;

   logic               pix_we, pix_re;
   logic [PIX_AW-1:0]  pix_waddr, pix_raddr;
   logic [PIX_W-1:0]   pix_wdata, pix_rdata;
   logic               tab_we, tab_re;
   logic [EXP_AW-1:0]  tab_waddr, tab_raddr;
   logic [TAB_W-1:0]   tab_wdata, tab_rdata;

   logic               mul_start, mul_done;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_prod;
   logic               div_start, div_done;
   logic [DIV_Q_W-1:0] div_quot;

   logic [8:0] w_eff, h_eff;
   logic       req_accept;

   // |pos*256 - center|
   function automatic logic [24:0] mag_fn(input logic [7:0] pos,
                                          input logic signed [23:0] ctr);
      logic signed [25:0] d;
      d = $signed({10'd0, pos, 8'd0}) - 26'(ctr);
      mag_fn = d[25] ? 25'(-d) : d[24:0];
   endfunction

   // drop 8 fraction bits, rounding toward zero
   function automatic logic signed [17:0] trunc_fn(input logic signed [25:0] v);
      logic [25:0] m;
      m = v[25] ? 26'(-v) : v;
      trunc_fn = v[25] ? -$signed(m[25:8]) : $signed(m[25:8]);
   endfunction

   function automatic logic [22:0] ratio_fn(input logic [MUL_P_W-1:0] p);
      ratio_fn = (p[95:40] > 56'(RATIO_CAP)) ? RATIO_CAP : p[62:40];
   endfunction

   function automatic logic [48:0] add_fn(input logic [MUL_P_W-1:0] p);
      add_fn = (p[95:30] > 66'(ADD_CAP)) ? ADD_CAP : p[78:30];
   endfunction

   assign w_eff = (width_ff > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && (state_ff == ST_IDLE);

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.read_value     = rsp_value_ff;
   assign rsp_ch.saturated_seen = rsp_sat_ff;

   always_comb begin
      logic [16:0]        ld_addr;
      logic               in_image;
      logic [12:0]        scale;
      logic [28:0]        hx_prod, hy_prod;
      logic signed [25:0] lo_x, hi_x, lo_y, hi_y;
      logic signed [17:0] t_minx, t_maxx, t_miny, t_maxy;
      logic signed [17:0] c_minx, c_maxx, c_miny, c_maxy;
      logic signed [17:0] w_last, h_last;
      logic [45:0]        usum;
      logic [44:0]        u;
      logic [IDX_W-1:0]   idx_full;
      logic [EXP_AW:0]    idx;
      logic signed [49:0] sum;
      logic               advance;

      state_in     = state_ff;
      mop_in       = mop_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      add_sigma_in = add_sigma_ff;
      sat_in       = sat_ff;
      init_k_in    = init_k_ff;
      tab_val_in   = tab_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      rd_inside_in = rd_inside_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      inten_in     = inten_ff;
      hwx_in       = hwx_ff;
      hwy_in       = hwy_ff;
      sxsy_in      = sxsy_ff;
      minx_in      = minx_ff;
      maxx_in      = maxx_ff;
      miny_in      = miny_ff;
      maxy_in      = maxy_ff;
      curx_in      = curx_ff;
      cury_in      = cury_ff;
      r_in         = r_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      norm_in      = norm_ff;
      peak_in      = peak_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rx2_in       = rx2_ff;
      ry2_in       = ry2_ff;
      add_in       = add_ff;
      row_base_in  = row_base_ff;

      pix_we    = 1'b0;
      pix_waddr = '0;
      pix_wdata = '0;
      pix_re    = 1'b0;
      pix_raddr = '0;
      tab_we    = 1'b0;
      tab_waddr = init_k_ff;
      tab_wdata = tab_val_ff;
      tab_re    = 1'b0;
      tab_raddr = '0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      advance   = 1'b0;

      ld_addr  = 17'(req_ch.pixel_row) * 17'(w_eff) + 17'(req_ch.pixel_col);
      in_image = (9'(req_ch.pixel_col) < w_eff) && (9'(req_ch.pixel_row) < h_eff);

      scale   = 13'(SCALE_BASE) + 13'(add_sigma_ff);
      hx_prod = 29'(sx_ff) * 29'(scale);
      hy_prod = 29'(sy_ff) * 29'(scale);

      lo_x   = 26'(cx_ff) - 26'(hwx_ff);
      hi_x   = 26'(cx_ff) + 26'(hwx_ff) + 26'sd256;
      lo_y   = 26'(cy_ff) - 26'(hwy_ff);
      hi_y   = 26'(cy_ff) + 26'(hwy_ff) + 26'sd256;
      t_minx = trunc_fn(lo_x);
      t_maxx = trunc_fn(hi_x);
      t_miny = trunc_fn(lo_y);
      t_maxy = trunc_fn(hi_y);
      w_last = $signed({9'd0, w_eff}) - 18'sd1;
      h_last = $signed({9'd0, h_eff}) - 18'sd1;
      c_minx = (t_minx < 18'sd0) ? 18'sd0 : t_minx;
      c_miny = (t_miny < 18'sd0) ? 18'sd0 : t_miny;
      c_maxx = (t_maxx > w_last) ? w_last : t_maxx;
      c_maxy = (t_maxy > h_last) ? h_last : t_maxy;

      usum     = 46'(rx2_ff) + 46'(ry2_ff);
      u        = usum[45:1];
      idx_full = IDX_W'(u[35:0]) * IDX_W'(EXP_TABLE_DEPTH) + (IDX_W'(1) << 35);
      idx      = idx_full[IDX_W-1:36];

      sum = 50'($signed(pix_rdata)) + $signed({1'b0, add_ff});

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            tab_we     = 1'b1;
            init_k_in  = init_k_ff + 1'b1;
            tab_val_in = TAB_W'((62'(tab_val_ff) * 62'(EXP_STEP) + 62'(1 << 29)) >> 30);
            if (init_k_ff == EXP_AW'(EXP_TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (kind_type'(req_ch.kind))
                  KIND_LOAD: begin
                     if (in_image) begin
                        pix_we    = 1'b1;
                        pix_waddr = ld_addr[PIX_AW-1:0];
                        pix_wdata = req_ch.load_value;
                     end
                  end
                  KIND_DRAW: begin
                     cx_in    = req_ch.spot_x;
                     cy_in    = req_ch.spot_y;
                     sx_in    = req_ch.sigma_x;
                     sy_in    = req_ch.sigma_y;
                     inten_in = req_ch.intensity;
                     if (req_ch.sigma_x != '0 && req_ch.sigma_y != '0) begin
                        state_in = ST_DR_HW;
                     end
                  end
                  KIND_READ: begin
                     pix_re       = 1'b1;
                     pix_raddr    = ld_addr[PIX_AW-1:0];
                     rd_inside_in = in_image;
                     state_in     = ST_RD_OUT;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_inside_ff ? $signed(pix_rdata) : '0;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_DR_HW: begin
            hwx_in   = hx_prod[28:8];
            hwy_in   = hy_prod[28:8];
            sxsy_in  = 32'(sx_ff) * 32'(sy_ff);
            state_in = ST_DR_WIN;
         end
         ST_DR_WIN: begin
            minx_in = c_minx;
            maxx_in = c_maxx;
            miny_in = c_miny;
            maxy_in = c_maxy;
            if (c_minx > c_maxx || c_miny > c_maxy) begin
               state_in = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DR_DIV;
            end
         end
         ST_DR_DIV: begin
            if (div_done) begin
               r_in     = div_quot;
               mop_in   = MOP_AX;
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            mul_start = 1'b1;
            case (mop_ff)
               MOP_AX:   begin mul_a = 64'(r_ff);    mul_b = 32'(sy_ff);             end
               MOP_AY:   begin mul_a = 64'(r_ff);    mul_b = 32'(sx_ff);             end
               MOP_NORM: begin mul_a = 64'(r_ff);    mul_b = 32'(INV_2PI_Q32);       end
               MOP_PEAK: begin mul_a = 64'(norm_ff); mul_b = 32'(inten_ff);          end
               MOP_RY:   begin
                  mul_a = 64'(ay_ff);
                  mul_b = 32'(mag_fn(cury_ff[7:0], cy_ff));
               end
               MOP_RY2:  begin mul_a = 64'(ry_ff);   mul_b = 32'(ry_ff);             end
               MOP_RX:   begin
                  mul_a = 64'(ax_ff);
                  mul_b = 32'(mag_fn(curx_ff[7:0], cx_ff));
               end
               MOP_RX2:  begin mul_a = 64'(rx_ff);   mul_b = 32'(rx_ff);             end
               MOP_ADD:  begin mul_a = 64'(peak_ff); mul_b = 32'(tab_rdata);         end
               default:  begin mul_a = '0;           mul_b = '0;                     end
            endcase
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = ST_MUL_GO;
               case (mop_ff)
                  MOP_AX: begin
                     ax_in  = mul_prod[DIV_Q_W-1:0];
                     mop_in = MOP_AY;
                  end
                  MOP_AY: begin
                     ay_in  = mul_prod[DIV_Q_W-1:0];
                     mop_in = MOP_NORM;
                  end
                  MOP_NORM: begin
                     norm_in = mul_prod[85:32];
                     mop_in  = MOP_PEAK;
                  end
                  MOP_PEAK: begin
                     peak_in  = mul_prod[78:28];
                     cury_in  = miny_ff;
                     state_in = ST_ROW;
                  end
                  MOP_RY: begin
                     ry_in  = ratio_fn(mul_prod);
                     mop_in = MOP_RY2;
                  end
                  MOP_RY2: begin
                     ry2_in  = mul_prod[44:0];
                     curx_in = minx_ff;
                     mop_in  = MOP_RX;
                  end
                  MOP_RX: begin
                     rx_in  = ratio_fn(mul_prod);
                     mop_in = MOP_RX2;
                  end
                  MOP_RX2: begin
                     rx2_in   = mul_prod[44:0];
                     state_in = ST_IDX;
                  end
                  MOP_ADD: begin
                     add_in   = add_fn(mul_prod);
                     state_in = ST_ACC;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ROW: begin
            row_base_in = PIX_AW'(17'(cury_ff[7:0]) * 17'(w_eff));
            mop_in      = MOP_RY;
            state_in    = ST_MUL_GO;
         end
         ST_IDX: begin
            // beyond the table the pixel gets nothing
            if (u[44:36] == '0 && idx < (EXP_AW + 1)'(EXP_TABLE_DEPTH)) begin
               tab_re    = 1'b1;
               tab_raddr = idx[EXP_AW-1:0];
               pix_re    = 1'b1;
               pix_raddr = row_base_ff + PIX_AW'(curx_ff[7:0]);
               state_in  = ST_FETCH;
            end else begin
               advance = 1'b1;
            end
         end
         ST_FETCH: begin
            mop_in   = MOP_ADD;
            state_in = ST_MUL_GO;
         end
         ST_ACC: begin
            pix_we    = 1'b1;
            pix_waddr = row_base_ff + PIX_AW'(curx_ff[7:0]);
            if (sum > 50'(PIX_MAX)) begin
               pix_wdata = PIX_MAX;
               sat_in    = 1'b1;
            end else begin
               pix_wdata = sum[PIX_W-1:0];
            end
            advance = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase

      if (advance) begin
         if (curx_ff < maxx_ff) begin
            curx_in  = curx_ff + 18'sd1;
            mop_in   = MOP_RX;
            state_in = ST_MUL_GO;
         end else if (cury_ff < maxy_ff) begin
            cury_in  = cury_ff + 18'sd1;
            state_in = ST_ROW;
         end else begin
            state_in = ST_IDLE;
         end
      end

      if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in     = csr_wdata[8:0];
            CSR_IMAGE_HEIGHT: height_in    = csr_wdata[8:0];
            CSR_ADD_SIGMA:    add_sigma_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         mop_ff       <= MOP_AX;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
         add_sigma_ff <= '0;
         sat_ff       <= 1'b0;
         init_k_ff    <= '0;
         tab_val_ff   <= TAB_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mop_ff       <= mop_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         add_sigma_ff <= add_sigma_in;
         sat_ff       <= sat_in;
         init_k_ff    <= init_k_in;
         tab_val_ff   <= tab_val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
      rd_inside_ff <= rd_inside_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      inten_ff     <= inten_in;
      hwx_ff       <= hwx_in;
      hwy_ff       <= hwy_in;
      sxsy_ff      <= sxsy_in;
      minx_ff      <= minx_in;
      maxx_ff      <= maxx_in;
      miny_ff      <= miny_in;
      maxy_ff      <= maxy_in;
      curx_ff      <= curx_in;
      cury_ff      <= cury_in;
      r_ff         <= r_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      norm_ff      <= norm_in;
      peak_ff      <= peak_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rx2_ff       <= rx2_in;
      ry2_ff       <= ry2_in;
      add_ff       <= add_in;
      row_base_ff  <= row_base_in;
   end

   gss_ram #(.WIDTH(PIX_W), .DEPTH(PIX_DEPTH)) u_pix_ram (
      .clock (clock),
      .we    (pix_we),
      .waddr (pix_waddr),
      .wdata (pix_wdata),
      .re    (pix_re),
      .raddr (pix_raddr),
      .rdata (pix_rdata)
   );

   gss_ram #(.WIDTH(TAB_W), .DEPTH(EXP_TABLE_DEPTH)) u_exp_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (tab_waddr),
      .wdata (tab_wdata),
      .re    (tab_re),
      .raddr (tab_raddr),
      .rdata (tab_rdata)
   );

   gss_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   gss_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (sxsy_ff),
      .done    (div_done),
      .quot    (div_quot)
   );

endmodule
